// ----- sv/stbs_pkg.sv -----
// Package for the sorted table binary search block.
// Holds table geometry, operation codes and controller/datapath structs.
// No dependencies.
package stbs_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned POS_W       = 10;
  localparam int unsigned EIDX_W      = 10;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PROBE = 4'b0010,
    S_CMP   = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  typedef struct packed {
    logic start;
    logic wr;
    logic probe;
    logic step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic hit;
    logic out_busy;
  } status_t;

endpackage

// ----- sv/stbs_if.sv -----
// Handshake channels of the sorted table binary search block.
// Input beats carry operation, index and key; output beats carry the result.
// Depends on stbs_pkg.
interface stbs_in_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [stbs_pkg::EIDX_W-1:0]    entry_index;
  logic signed [stbs_pkg::KEY_W-1:0] key;

  modport source (output valid, operation, entry_index, key, input ready);
  modport sink   (input valid, operation, entry_index, key, output ready);
endinterface

interface stbs_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [stbs_pkg::POS_W-1:0]  position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

// ----- sv/sorted_table_binary_search.sv -----
// Sorted table binary search, top level: joins controller and datapath.
// A write beat is taken while idle. A search makes p probes, at most 11 over 1024
// entries, each a registered table read in S_PROBE then a compare in S_CMP.
// One item is worked at a time; a held result stalls only a finished search,
// never writes.
// Reset clears count, state and result valid; table is not reset.
module sorted_table_binary_search (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [stbs_pkg::CNT_W-1:0] cfg_wdata_i,
  stbs_in_if.sink                    in_ch,
  stbs_out_if.source                 out_ch
);

  stbs_pkg::cmd_t    cmd;
  stbs_pkg::status_t status;

  stbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_op_i     (in_ch.operation),
    .in_ready_o  (in_ch.ready),
    .out_ready_i (out_ch.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  stbs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .entry_index_i (in_ch.entry_index),
    .key_i         (in_ch.key),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .found_o       (out_ch.found),
    .position_o    (out_ch.position)
  );

  a_no_accept_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.probe || cmd.step) |-> !in_ch.ready)
    else $error("input accepted during search");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (!out_ch.valid || out_ch.ready))
    else $error("pending result overwritten");

  a_miss_position_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.found) |-> (out_ch.position == '0))
    else $error("miss with non-zero position");

  a_start_then_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> !in_ch.ready)
    else $error("search did not leave idle");

endmodule

// ----- sv/stbs_ctrl.sv -----
// Controller of the sorted table binary search block.
// One-hot state machine that sequences probes of the datapath.
// Depends on stbs_pkg.
module stbs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  input  stbs_pkg::status_t status_i,
  output stbs_pkg::cmd_t    cmd_o
);

  stbs_pkg::state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      stbs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == stbs_pkg::OP_SEARCH) begin
            cmd_o.start = 1'b1;
            state_d     = stbs_pkg::S_PROBE;
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      stbs_pkg::S_PROBE: begin
        if (status_i.empty) begin
          state_d = stbs_pkg::S_DONE;
        end else begin
          cmd_o.probe = 1'b1;
          state_d     = stbs_pkg::S_CMP;
        end
      end
      stbs_pkg::S_CMP: begin
        cmd_o.step = 1'b1;
        state_d    = status_i.hit ? stbs_pkg::S_DONE : stbs_pkg::S_PROBE;
      end
      stbs_pkg::S_DONE: begin
        if (!status_i.out_busy || out_ready_i) begin
          cmd_o.load = 1'b1;
          state_d    = stbs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = stbs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stbs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/stbs_dp.sv -----
// Datapath of the sorted table binary search block.
// Table memory, search range registers, count register and result register.
// Depends on stbs_pkg.
module stbs_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [stbs_pkg::CNT_W-1:0]        cfg_wdata_i,
  input  logic [stbs_pkg::EIDX_W-1:0]       entry_index_i,
  input  logic signed [stbs_pkg::KEY_W-1:0] key_i,
  input  stbs_pkg::cmd_t                    cmd_i,
  output stbs_pkg::status_t                 status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              found_o,
  output logic [stbs_pkg::POS_W-1:0]        position_o
);

  logic [stbs_pkg::KEY_W-1:0] mem [stbs_pkg::TABLE_DEPTH];

  logic [stbs_pkg::CNT_W-1:0]        count_q;
  logic [stbs_pkg::CNT_W-1:0]        count_sat;
  logic [stbs_pkg::CNT_W-1:0]        lo_q, hi_q;
  logic [stbs_pkg::CNT_W-1:0]        mid_c;
  logic [stbs_pkg::IDX_W-1:0]        mid_q;
  logic signed [stbs_pkg::KEY_W-1:0] key_q;
  logic signed [stbs_pkg::KEY_W-1:0] rd_q;
  logic                              hit_q;
  logic                              out_valid_q;
  logic                              found_q;
  logic [stbs_pkg::POS_W-1:0]        position_q;
  logic                              hit_c;
  logic                              wr_fits;

  assign count_sat = (count_q > stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH))
                   ? stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH) : count_q;
  assign mid_c     = lo_q + ((hi_q - lo_q - stbs_pkg::CNT_W'(1)) >> 1);
  assign hit_c     = (rd_q == key_q);
  assign wr_fits   = (32'(entry_index_i) < stbs_pkg::TABLE_DEPTH);

  assign status_o.empty    = (lo_q >= hi_q);
  assign status_o.hit      = hit_c;
  assign status_o.out_busy = out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && wr_fits) begin
      mem[entry_index_i[stbs_pkg::IDX_W-1:0]] <= key_i;
    end
    rd_q <= mem[mid_c[stbs_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q <= key_i;
      lo_q  <= '0;
      hi_q  <= count_sat;
    end else if (cmd_i.step && !hit_c) begin
      if (key_q > rd_q) begin
        lo_q <= {1'b0, mid_q} + stbs_pkg::CNT_W'(1);
      end else begin
        hi_q <= {1'b0, mid_q};
      end
    end
    if (cmd_i.probe) begin
      mid_q <= mid_c[stbs_pkg::IDX_W-1:0];
    end
    if (cmd_i.load) begin
      found_q    <= hit_q;
      position_q <= hit_q ? stbs_pkg::POS_W'(mid_q) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (cmd_i.start) begin
        hit_q <= 1'b0;
      end else if (cmd_i.step && hit_c) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign position_o  = position_q;

endmodule
